@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/sci_pkg.sv @@
// ---------------------------------------------------------------------------
// sci_pkg
// Types and constants of the sphere chain interpolator.
// ---------------------------------------------------------------------------
package sci_pkg;

    localparam int MAX_OUTPUTS = 64;
    localparam int K_W         = $clog2(MAX_OUTPUTS + 1);
    localparam logic [15:0] RATIO_RESET = 16'd512;

    typedef struct packed {
        logic signed [31:0] first_center_x;
        logic signed [31:0] first_center_y;
        logic signed [31:0] first_center_z;
        logic        [30:0] first_radius;
        logic signed [31:0] second_center_x;
        logic signed [31:0] second_center_y;
        logic signed [31:0] second_center_z;
        logic        [30:0] second_radius;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [30:0] out_radius;
        logic               last_of_run;
        logic               truncated;
    } t_out_item;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SQUARE = 7'b0000010,
        S_ROOT   = 7'b0000100,
        S_DIVIDE = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_SCALE  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

endpackage

@@ hw/rtl/sphere_chain_interpolator_unit.sv @@
// ---------------------------------------------------------------------------
// sphere_chain_interpolator_unit
// Fills the segment between two spheres with evenly spaced spheres.
// ---------------------------------------------------------------------------
// One pair word is taken at a time; the input is not ready until the last
// sphere of the pair has been loaded into the output register. A pair goes
// through squaring (one 32x32 multiplier), digit-by-digit square root,
// restoring division for the step, a check and shift-add scaling (each
// coordinate and the radius in turn through one shared add/compare unit),
// then emits one sphere per cycle while the output side takes words. Pairs
// with no result return to idle after the check. Spheres are produced by
// exact incremental quotient/remainder accumulation, so rounding matches a
// full divide.
// ---------------------------------------------------------------------------
module sphere_chain_interpolator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sci_pkg::t_in_item i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output sci_pkg::t_out_item o_data,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);
    import sci_pkg::*;
    `include "assert_macros.svh"

    t_state        r_state;
    logic [15:0]   r_ratio;
    logic [31:0]   r_base [4];
    logic          r_neg  [4];
    logic [31:0]   r_mag  [4];
    logic [30:0]   r_rmin;
    logic [63:0]   r_prod;
    logic [65:0]   r_sum;
    logic [33:0]   r_root;
    logic [35:0]   r_srem;
    logic [38:0]   r_step;
    logic [15:0]   r_drem;
    logic [6:0]    r_cnt;
    logic [31:0]   r_qa   [4];
    logic [33:0]   r_ra   [4];
    logic [31:0]   r_acc  [4];
    logic [33:0]   r_rem  [4];
    logic [34:0]   r_len;
    logic [K_W-1:0] r_k;
    logic          r_trunc;
    logic          r_o_valid;
    t_out_item     r_o_data;

    // shared read of the magnitude file
    logic [1:0]  lane_sel;
    logic [31:0] sel_mag;

    // accept-time differences
    logic [32:0] diff [4];
    logic [31:0] base_in [4];

    // root step
    logic [37:0] srem_sh, root_trial;
    logic        root_ge;

    // divide step
    logic [16:0] dsh;
    logic        div_ge;

    // scale step
    logic [33:0] step34;
    logic [35:0] sc_t, sc_d1, sc_d2;
    logic [33:0] sc_ra;
    logic [1:0]  sc_digit;

    // check
    logic [46:0] trunc_len;
    logic        no_run;

    // emit lanes
    logic [34:0] em_sum  [4];
    logic        em_wrap [4];
    logic [33:0] em_rem  [4];
    logic [31:0] em_acc  [4];
    logic [31:0] em_val  [4];
    logic [K_W-1:0] k_next;
    logic [34:0] len_next;
    logic        em_last, em_load;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    always_comb begin
        lane_sel = (r_state == S_SCALE) ? r_cnt[6:5] : r_cnt[1:0];
        sel_mag  = r_mag[lane_sel];
    end

    // signed differences of the pair; radius differences are zero-extended
    always_comb begin
        diff[0] = {i_data.second_center_x[31], i_data.second_center_x}
                - {i_data.first_center_x[31], i_data.first_center_x};
        diff[1] = {i_data.second_center_y[31], i_data.second_center_y}
                - {i_data.first_center_y[31], i_data.first_center_y};
        diff[2] = {i_data.second_center_z[31], i_data.second_center_z}
                - {i_data.first_center_z[31], i_data.first_center_z};
        diff[3] = {2'b00, i_data.second_radius} - {2'b00, i_data.first_radius};
        base_in[0] = i_data.first_center_x;
        base_in[1] = i_data.first_center_y;
        base_in[2] = i_data.first_center_z;
        base_in[3] = {1'b0, i_data.first_radius};
    end

    // two radicand bits per step
    always_comb begin
        srem_sh    = {r_srem, r_sum[65:64]};
        root_trial = {2'b00, r_root, 2'b01};
        root_ge    = (srem_sh >= root_trial);
    end

    always_comb begin
        dsh    = {r_drem, r_step[38]};
        div_ge = (dsh >= {1'b0, r_ratio});
    end

    // remainder times two plus step if the magnitude bit is set, then reduce
    always_comb begin
        step34 = r_step[33:0];
        sc_t   = {1'b0, r_ra[lane_sel], 1'b0} + (sel_mag[31] ? {2'b00, step34} : 36'd0);
        sc_d1  = {2'b00, r_root};
        sc_d2  = {1'b0, r_root, 1'b0};
        if (sc_t >= sc_d2) begin
            sc_digit = 2'd2;
            sc_ra    = 34'(sc_t - sc_d2);
        end else if (sc_t >= sc_d1) begin
            sc_digit = 2'd1;
            sc_ra    = 34'(sc_t - sc_d1);
        end else begin
            sc_digit = 2'd0;
            sc_ra    = sc_t[33:0];
        end
    end

    always_comb begin
        trunc_len = {8'b0, r_step} * 47'(MAX_OUTPUTS + 1);
        no_run    = (r_ratio == 16'd0) || (r_root == 34'd0) || (r_step == 39'd0)
                  || (r_step >= {5'b0, r_root});
    end

    // next sphere: add quotient and remainder increments per lane
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            em_sum[j]  = {1'b0, r_rem[j]} + {1'b0, r_ra[j]};
            em_wrap[j] = (em_sum[j] >= {1'b0, r_root});
            em_rem[j]  = em_wrap[j] ? 34'(em_sum[j] - {1'b0, r_root}) : em_sum[j][33:0];
            em_acc[j]  = r_acc[j] + r_qa[j] + {31'b0, em_wrap[j]};
            em_val[j]  = r_neg[j] ? (r_base[j] - em_acc[j]) : (r_base[j] + em_acc[j]);
        end
        k_next   = r_k + K_W'(1);
        len_next = r_len + {1'b0, step34};
        em_last  = (k_next == K_W'(MAX_OUTPUTS)) || (len_next >= {1'b0, r_root});
        em_load  = (r_state == S_EMIT) && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ratio   <= RATIO_RESET;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_k       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ratio <= i_cfg_data;
            end

            // drop the output word once taken, unless a new one replaces it
            if (em_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int j = 0; j < 4; j++) begin
                            r_base[j] <= base_in[j];
                            r_neg[j]  <= diff[j][32];
                            r_mag[j]  <= diff[j][32] ? 32'(-diff[j]) : diff[j][31:0];
                        end
                        r_rmin  <= (i_data.first_radius < i_data.second_radius)
                                   ? i_data.first_radius : i_data.second_radius;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_prod <= sel_mag * sel_mag;
                    if (r_cnt != 7'd0) begin
                        r_sum <= r_sum + {2'b00, r_prod};
                    end
                    if (r_cnt == 7'd3) begin
                        r_cnt   <= '0;
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ROOT: begin
                    r_sum <= {r_sum[63:0], 2'b00};
                    if (root_ge) begin
                        r_srem <= 36'(srem_sh - root_trial);
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_srem <= srem_sh[35:0];
                        r_root <= {r_root[32:0], 1'b0};
                    end
                    if (r_cnt == 7'd32) begin
                        r_cnt   <= '0;
                        r_drem  <= '0;
                        r_step  <= {r_rmin, 8'b0};
                        r_state <= S_DIVIDE;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DIVIDE: begin
                    r_drem <= div_ge ? 16'(dsh - {1'b0, r_ratio}) : dsh[15:0];
                    r_step <= {r_step[37:0], div_ge};
                    if (r_cnt == 7'd38) begin
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_CHECK: begin
                    if (no_run) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_trunc <= (trunc_len < {13'b0, r_root});
                        r_len   <= {1'b0, r_step[33:0]};
                        for (int j = 0; j < 4; j++) begin
                            r_qa[j] <= '0;
                            r_ra[j] <= '0;
                        end
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_qa[lane_sel]  <= {r_qa[lane_sel][30:0], 1'b0} + {30'b0, sc_digit};
                    r_ra[lane_sel]  <= sc_ra;
                    r_mag[lane_sel] <= {sel_mag[30:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_k <= '0;
                        for (int j = 0; j < 4; j++) begin
                            r_acc[j] <= '0;
                            r_rem[j] <= {1'b0, r_root[33:1]};
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (em_load) begin
                        for (int j = 0; j < 4; j++) begin
                            r_acc[j] <= em_acc[j];
                            r_rem[j] <= em_rem[j];
                        end
                        r_k   <= k_next;
                        r_len <= len_next;
                        r_o_data.out_x       <= em_val[0];
                        r_o_data.out_y       <= em_val[1];
                        r_o_data.out_z       <= em_val[2];
                        r_o_data.out_radius  <= em_val[3][30:0];
                        r_o_data.last_of_run <= em_last;
                        r_o_data.truncated   <= r_trunc;
                        if (em_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a sphere still to be emitted never exceeds the cap or the distance
    `ASSERT_IMP(a_k_below_cap, i_clk, i_rst_n, r_state == S_EMIT, r_k < K_W'(MAX_OUTPUTS))
    `ASSERT_IMP(a_len_below_dist, i_clk, i_rst_n, r_state == S_EMIT, r_len < {1'b0, r_root})
    // the running remainder of the first lane stays reduced
    `ASSERT_IMP(a_rem_reduced, i_clk, i_rst_n, r_state == S_EMIT, r_rem[0] < r_root)
    // leaving the emit phase always leaves a final word in the output register
    `ASSERT_NXT(a_last_loaded, i_clk, i_rst_n, em_load && em_last,
                r_o_valid && r_o_data.last_of_run)

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for sphere_chain_interpolator_unit.
// ---------------------------------------------------------------------------
// Sphere pairs are queued by the stimulus process and offered by a clocked
// driver. A clocked monitor takes the output words. Each accepted pair is run
// through a local bit-exact model of the chain fill. The model covers the
// exact square root, the step and count, capping, and rounded interpolation.
// The expected spheres are queued and matched field by field in order.
// Both sides idle at random. The bench also holds off the output for a long
// stretch and walks the ratio register through several settings.
// ---------------------------------------------------------------------------
module tb;
    import sci_pkg::*;

    localparam int  LIMIT_CYCLES = 1_500_000;
    localparam int  SETTLE       = 300;
    localparam int  NUM_RANDOM   = 180;
    localparam int  HOLD_CYCLES  = 3000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    t_in_item   pair_q[$];
    t_out_item  sphere_q[$];
    logic [15:0] ratio_reg = RATIO_RESET;

    bit         steady = 1'b0;   // no idling on either side while set
    bit         hold_start = 1'b0;
    bit         hold_done = 1'b0;
    int         rx_hold = 0;     // long output hold-off, in cycles
    int         cycles = 0;
    int         mismatches = 0;
    int         pairs_sent = 0;
    int         spheres_seen = 0;
    int         cut_runs = 0;

    sphere_chain_interpolator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // a + sign(diff) * round(|diff| * len / seg_len), halves away from zero
    function automatic longint interp(longint a, longint diff,
                                      longint unsigned len, longint unsigned seg_len);
        longint unsigned mag;
        logic [95:0]     num;
        logic [95:0]     q;
        mag = (diff < 0) ? longint'(-diff) : longint'(diff);
        num = 96'(mag) * 96'(len) + 96'(seg_len >> 1);
        q   = num / 96'(seg_len);
        return (diff < 0) ? a - longint'(q) : a + longint'(q);
    endfunction

    // Expand one pair into its chain of spheres.
    function automatic void fill_chain(t_in_item p, logic [15:0] ratio);
        longint          x1, y1, z1, r1, dx, dy, dz, dr;
        longint unsigned ax, ay, az, seg_len, cand, rmin, step, count, emit, len;
        logic [95:0]     sumsq;
        t_out_item       s;
        x1 = longint'(p.first_center_x);
        y1 = longint'(p.first_center_y);
        z1 = longint'(p.first_center_z);
        r1 = longint'({1'b0, p.first_radius});
        dx = longint'(p.second_center_x) - x1;
        dy = longint'(p.second_center_y) - y1;
        dz = longint'(p.second_center_z) - z1;
        dr = longint'({1'b0, p.second_radius}) - r1;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        sumsq = 96'(ax) * 96'(ax) + 96'(ay) * 96'(ay) + 96'(az) * 96'(az);
        seg_len = 0;
        for (int b = 34; b >= 0; b--) begin
            cand = seg_len | (64'd1 << b);
            if (96'(cand) * 96'(cand) <= sumsq)
                seg_len = cand;
        end
        if (ratio == 0)
            return;
        rmin = (p.first_radius < p.second_radius) ? p.first_radius : p.second_radius;
        step = (rmin << 8) / ratio;
        if (seg_len == 0 || step == 0)
            return;
        count = (seg_len - 1) / step;
        emit  = (count > MAX_OUTPUTS) ? MAX_OUTPUTS : count;
        if (count > MAX_OUTPUTS)
            cut_runs++;
        for (longint unsigned k = 1; k <= emit; k++) begin
            len = k * step;
            s.out_x       = 32'(interp(x1, dx, len, seg_len));
            s.out_y       = 32'(interp(y1, dy, len, seg_len));
            s.out_z       = 32'(interp(z1, dz, len, seg_len));
            s.out_radius  = 31'(interp(r1, dr, len, seg_len));
            s.last_of_run = (k == emit);
            s.truncated   = (count > MAX_OUTPUTS);
            sphere_q = {sphere_q, s};
        end
    endfunction

    // Driver: offer queued pairs, hold valid and payload until taken.
    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = i_valid;
        nxt_data  = i_data;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                fill_chain(i_data, ratio_reg);
                pairs_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pair_q.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
                nxt_valid = 1'b1;
                nxt_data  = pair_q.pop_front();
            end
        end
        i_valid <= nxt_valid;
        i_data  <= nxt_data;
    end

    // Hold-off counter: start once on request, then count down.
    always @(posedge i_clk) begin
        if (hold_start && !hold_done) begin
            hold_done <= 1'b1;
            rx_hold   <= HOLD_CYCLES;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Monitor: take output words and match them against the expected chain.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            spheres_seen++;
            if (sphere_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sphere %p", o_data);
            end else begin
                want = sphere_q.pop_front();
                if (want.out_x !== o_data.out_x || want.out_y !== o_data.out_y ||
                    want.out_z !== o_data.out_z || want.out_radius !== o_data.out_radius ||
                    want.last_of_run !== o_data.last_of_run ||
                    want.truncated !== o_data.truncated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sphere mismatch: expected %p, got %p", want, o_data);
                end
            end
        end
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n && (steady || $urandom_range(99) >= 30);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("[sphere_chain_interpolator_unit] ERROR");
            $finish;
        end
    end

    function automatic t_in_item make_pair(logic signed [31:0] x1, logic signed [31:0] y1,
                                           logic signed [31:0] z1, logic [30:0] r1,
                                           logic signed [31:0] x2, logic signed [31:0] y2,
                                           logic signed [31:0] z2, logic [30:0] r2);
        t_in_item p;
        p = '{x1, y1, z1, r1, x2, y2, z2, r2};
        return p;
    endfunction

    // Shift a coordinate by d, reflecting the offset if it would wrap.
    function automatic logic signed [31:0] nudge(logic signed [31:0] c, longint d);
        longint v;
        v = longint'(c) + d;
        if (v > 64'sd2147483647 || v < -64'sd2147483648)
            v = longint'(c) - d;
        return 32'(v);
    endfunction

    // Random pair, mostly with a chain length around the cap.
    function automatic t_in_item rand_pair();
        t_in_item p;
        int       e;
        longint   span;
        if ($urandom_range(99) < 20) begin
            p = {$urandom, $urandom, $urandom, 31'($urandom),
                 $urandom, $urandom, $urandom, 31'($urandom)};
            return p;
        end
        e    = $urandom_range(4, 30);
        span = longint'(1) << e;
        p.first_center_x  = $urandom;
        p.first_center_y  = $urandom;
        p.first_center_z  = $urandom;
        p.second_center_x = nudge(p.first_center_x, $urandom_range(0, 2*span) - span);
        p.second_center_y = nudge(p.first_center_y, $urandom_range(0, 2*span) - span);
        p.second_center_z = nudge(p.first_center_z, $urandom_range(0, 2*span) - span);
        p.first_radius    = 31'($urandom_range(0, 32'(span >> $urandom_range(0, 9))));
        p.second_radius   = 31'($urandom_range(0, 32'(span >> $urandom_range(0, 9))));
        return p;
    endfunction

    // Wait until every queued pair is taken and every expected sphere seen.
    task automatic drain();
        do
            @(negedge i_clk);
        while (pair_q.size() != 0 || i_valid || sphere_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_ratio(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ratio_reg  = v;
    endtask

    initial begin
        logic [15:0] ratios[6];
        ratios = '{16'd256, 16'd65535, 16'd0, 16'd100, 16'd1000, 16'd300};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs under the reset ratio (2.0, step = rmin / 2).
        pair_q = {pair_q, make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                    31'h7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                    32'sh7fffffff, 31'h7fffffff)};
        pair_q = {pair_q, make_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                    31'h7fffffff, 32'sh80000000, 32'sh80000000,
                                    32'sh80000000, 31'h0)};
        // zero distance, zero radius
        pair_q = {pair_q, make_pair(100, -5, 7, 1000, 100, -5, 7, 2000)};
        pair_q = {pair_q, make_pair(0, 0, 0, 0, 5000, 0, 0, 300)};
        // step 100: distance 100 gives none, 6401 exactly the cap, 6501 one over
        pair_q = {pair_q, make_pair(0, 0, 0, 200, 100, 0, 0, 900)};
        pair_q = {pair_q, make_pair(0, 0, 0, 200, 6401, 0, 0, 900)};
        pair_q = {pair_q, make_pair(0, 0, 0, 900, -6501, 0, 0, 200)};
        pair_q = {pair_q, make_pair(10, 20, 30, 200, 10, -3000, 30, 200)};
        pair_q = {pair_q, make_pair(-7, 3, 9, 4000, 300, -200, 1000, 250)};
        pair_q = {pair_q, make_pair(1, 1, 1, 3, 2, 2, 2, 3)};
        pair_q = {pair_q, make_pair(0, 0, 0, 1, 0, 0, 1000, 1)};
        drain();

        // Fill the block while the output side holds off.
        steady = 1'b1;
        for (int i = 0; i < 20; i++)
            pair_q = {pair_q, rand_pair()};
        steady     = 1'b0;
        hold_start = 1'b1;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_ratio(ratios[ph]);
            if (ph == 2)
                steady = 1'b1;
            for (int i = 0; i < NUM_RANDOM / 6; i++)
                pair_q = {pair_q, rand_pair()};
            drain();
            steady = 1'b0;
        end
        write_ratio(RATIO_RESET);
        for (int i = 0; i < 10; i++)
            pair_q = {pair_q, rand_pair()};
        drain();

        $display("covered %0d pairs, %0d spheres checked, %0d capped runs, ratios 0..65535",
                 pairs_sent, spheres_seen, cut_runs);
        if (mismatches == 0 && sphere_q.size() == 0) begin
            $display("[sphere_chain_interpolator_unit] OK");
        end else begin
            $display("%0d mismatches, %0d spheres missing", mismatches, sphere_q.size());
            $display("[sphere_chain_interpolator_unit] ERROR");
        end
        $finish;
    end

endmodule
